FILE: rtl/fnvrs_pkg.sv
package fnvrs_pkg;

  localparam int HASH_W     = 64;
  localparam int BYTE_W     = 8;
  localparam int WC_W       = 9;
  localparam int ROUTE_W    = 8;
  localparam int CNT_W      = $clog2(HASH_W);
  localparam int PRIME_SHIFT = 40;
  localparam int PRIME_LO_W = 9;

  localparam logic [HASH_W-1:0]     FNV_BASIS   = 64'hcbf29ce484222325;
  // FNV prime = 2^40 + 0x1b3
  localparam logic [PRIME_LO_W-1:0] FNV_PRIME_LO = 9'h1b3;
  localparam logic [WC_W-1:0]       MAX_WORKERS = 9'd256;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_value;
    logic              has_byte;
    logic              last_byte;
  } in_item_t;

  typedef struct packed {
    logic [ROUTE_W-1:0] route;
    logic [HASH_W-1:0]  name_hash;
  } out_item_t;

  typedef struct packed {
    logic load_in;
    logic hash_upd;
    logic div_start;
    logic div_step;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic div_last;
  } dp_stat_t;

endpackage

FILE: rtl/fnvrs_dp.sv
module fnvrs_dp
  import fnvrs_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  in_item_t        in_data,
  input  logic            cfg_we,
  input  logic [WC_W-1:0] cfg_wdata,
  input  dp_cmd_t         cmd,
  output dp_stat_t        stat,
  output out_item_t       out_data
);

  logic [HASH_W-1:0]  hash_r, hash_nxt;
  logic [HASH_W-1:0]  mix_r;
  logic [HASH_W-1:0]  prod_r;
  logic [HASH_W-1:0]  name_r;
  logic [HASH_W-1:0]  quo_r;
  logic [ROUTE_W-1:0] rem_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [WC_W-1:0]    wc_r;
  out_item_t          out_r;

  logic [HASH_W-1:0]  mix;
  logic [HASH_W-1:0]  prod_nxt;
  logic [HASH_W-1:0]  sum;
  logic [HASH_W-1:0]  div_src;
  logic [WC_W-1:0]    n_eff;
  logic [WC_W-1:0]    trial;
  logic [ROUTE_W-1:0] rem_nxt;

  assign mix      = hash_r ^ {{(HASH_W-BYTE_W){1'b0}}, in_data.byte_value};
  assign prod_nxt = mix * {{(HASH_W-PRIME_LO_W){1'b0}}, FNV_PRIME_LO};
  assign sum      = prod_r + {mix_r[HASH_W-PRIME_SHIFT-1:0], {PRIME_SHIFT{1'b0}}};
  assign div_src  = cmd.hash_upd ? sum : hash_r;

  always_comb begin
    if (wc_r == '0) begin
      n_eff = WC_W'(1);
    end else if (wc_r > MAX_WORKERS) begin
      n_eff = MAX_WORKERS;
    end else begin
      n_eff = wc_r;
    end
  end

  // restoring division, one quotient bit per cycle; remainder < n_eff <= 256
  assign trial   = {rem_r, quo_r[HASH_W-1]};
  assign rem_nxt = (trial >= n_eff) ? ROUTE_W'(trial - n_eff) : trial[ROUTE_W-1:0];

  always_comb begin
    hash_nxt = hash_r;
    if (cmd.div_start) begin
      hash_nxt = FNV_BASIS;
    end else if (cmd.hash_upd) begin
      hash_nxt = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= FNV_BASIS;
      wc_r   <= WC_W'(1);
      cnt_r  <= '0;
    end else begin
      hash_r <= hash_nxt;
      if (cfg_we) begin
        wc_r <= cfg_wdata;
      end
      if (cmd.div_start) begin
        cnt_r <= '0;
      end else if (cmd.div_step) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mix_r  <= mix;
      prod_r <= prod_nxt;
    end
    if (cmd.div_start) begin
      quo_r  <= div_src;
      name_r <= div_src;
      rem_r  <= '0;
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[HASH_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
    if (cmd.out_load) begin
      out_r.route     <= rem_r;
      out_r.name_hash <= name_r;
    end
  end

  assign stat.div_last = (cnt_r == {CNT_W{1'b1}});
  assign out_data      = out_r;

endmodule

FILE: rtl/fnvrs_ctrl.sv
module fnvrs_ctrl
  import fnvrs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  in_item_t in_data,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ADD  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       last_r, last_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    last_nxt  = last_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          last_nxt    = in_data.last_byte;
          if (in_data.has_byte) begin
            state_nxt = S_ADD;
          end else if (in_data.last_byte) begin
            cmd.div_start = 1'b1;
            state_nxt     = S_DIV;
          end
        end
      end
      S_ADD: begin
        cmd.hash_upd = 1'b1;
        if (last_r) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // wait for the output register to free up
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = cmd.out_load | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: rtl/fnv1a_route_selector_top.sv
// Streaming FNV-1a 64-bit hash with modulo routing. A name arrives one byte
// per item; each byte item is accepted and then finished with a shift-add of
// the 2^40 + 0x1b3 prime multiply. An item marked last then runs a bit-serial
// remainder by the effective worker count (0 acts as 1, above 256 acts as
// 256) and then loads the output register. The input is stalled while a
// byte or the remainder is in progress; a finished result waits in the
// output register while the next name's bytes are taken, and if it is still
// waiting when the next result is ready, the block holds with its input
// stalled. The worker count is to be written by the user through
// cfg_we/cfg_wdata only while the block is idle; the block itself does not
// enforce this.
module fnv1a_route_selector_top
  import fnvrs_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  in_item_t        in_data,
  output logic            in_stall,
  output logic            out_valid,
  output out_item_t       out_data,
  input  logic            out_stall,
  input  logic            cfg_we,
  input  logic [WC_W-1:0] cfg_wdata
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  fnvrs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  fnvrs_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule
